// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the ranger RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/uer_pkg.sv -----
// ----------------------------------------------------------------------------
// uer_pkg
// Types and constants of the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

    localparam int SAMPLE_W = 12;
    localparam int THR_W    = 12;
    localparam int BURST_W  = 8;
    localparam int SETTLE_W = 8;
    localparam int TOUT_W   = 10;
    localparam int TICK_W   = 11;
    localparam int ECHO_W   = 11;
    localparam int FRAME_W  = 16;
    localparam int MIN_W    = SAMPLE_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Command codes.
    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_TICKS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS  = 2'd3;

    // Register reset values.
    localparam logic [THR_W-1:0]    THRESHOLD_RST = 12'd128;
    localparam logic [BURST_W-1:0]  BURST_RST     = 8'd8;
    localparam logic [SETTLE_W-1:0] SETTLE_RST    = 8'd20;
    localparam logic [TOUT_W-1:0]   TIMEOUT_RST   = 10'd250;

    // "No background seen yet": above any sample, and minimum plus any
    // threshold stays above any sample.
    localparam logic [MIN_W-1:0] MIN_NONE = 13'h1000;

    typedef enum logic [3:0] {
        PH_CHIRP  = 4'b0001,
        PH_SETTLE = 4'b0010,
        PH_DETECT = 4'b0100,
        PH_DONE   = 4'b1000
    } t_phase;

    typedef struct packed {
        logic                command;
        logic [SAMPLE_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic               drive_left;
        logic               drive_right;
        logic               side_left;
        logic               echo_found;
        logic [ECHO_W-1:0]  echo_count;
        logic [ECHO_W-1:0]  previous_echo;
        logic [FRAME_W-1:0] frame_number;
        logic               busy_res;
    } t_out_item;

endpackage

// ----- hdl/ultrasonic_echo_ranger.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Time-of-flight ranging controller: chirp, background tracking, echo detect.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in) carries one item per
//   frame start or carrier tick with its ADC sample. Each accepted item
//   yields exactly one result item on the output channel
//   (o_out_valid / i_out_ready / o_out), holding the state after the update.
//   The state and the result register load at the edge that accepts the item.
//   Throughput is one item per cycle while results are taken; the only limit
//   is the single result register, which is refilled in the cycle it drains.
//   When the receiver stalls, the result is held and o_in_ready drops until
//   it is taken; no item is lost or repeated.
//   The configuration channel (i_cfg_valid / o_cfg_ready) is always ready
//   and writes one register per accepted write; writes are expected only
//   while no result is outstanding.
//   Synchronous active-low reset returns the registers to their defaults,
//   clears the measurement state and empties the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ultrasonic_echo_ranger (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [uer_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  uer_pkg::t_in_item                  i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output uer_pkg::t_out_item                 o_out
);

    // Configuration registers.
    logic [uer_pkg::THR_W-1:0]    r_thr;
    logic [uer_pkg::BURST_W-1:0]  r_burst;
    logic [uer_pkg::SETTLE_W-1:0] r_settle;
    logic [uer_pkg::TOUT_W-1:0]   r_timeout;

    // Measurement state.
    uer_pkg::t_phase              r_phase, n_phase;
    logic [uer_pkg::TICK_W-1:0]   r_tick, n_tick;
    logic [uer_pkg::MIN_W-1:0]    r_min, n_min;
    logic                         r_left, n_left;
    logic                         r_running, n_running;
    logic [uer_pkg::ECHO_W-1:0]   r_echo, n_echo;
    logic [uer_pkg::ECHO_W-1:0]   r_last, n_last;
    logic [uer_pkg::FRAME_W-1:0]  r_frames, n_frames;
    logic                         r_drive, n_drive;
    logic                         n_found;

    // Result register.
    logic                         r_out_valid;
    uer_pkg::t_out_item           r_out, n_out;

    logic                         in_fire;
    logic                         cfg_fire;
    logic [uer_pkg::MIN_W-1:0]    smp_ext;
    logic [uer_pkg::MIN_W-1:0]    min_upd;
    logic [uer_pkg::MIN_W:0]      min_plus_thr;
    logic                         hit;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Background minimum including this sample, and the echo test against it.
    assign smp_ext      = {1'b0, i_in.sample};
    assign min_upd      = (smp_ext < r_min) ? smp_ext : r_min;
    assign min_plus_thr = {1'b0, min_upd} + {2'b00, r_thr};
    assign hit          = ({1'b0, smp_ext} > min_plus_thr);

    always_comb begin
        n_phase   = r_phase;
        n_tick    = r_tick;
        n_min     = r_min;
        n_left    = r_left;
        n_running = r_running;
        n_echo    = r_echo;
        n_last    = r_last;
        n_frames  = r_frames;
        n_drive   = r_drive;
        n_found   = 1'b0;

        if (i_in.command == uer_pkg::CMD_FRAME) begin
            n_left    = !r_left;
            n_tick    = {{(uer_pkg::TICK_W-uer_pkg::BURST_W){1'b0}}, r_burst};
            n_phase   = uer_pkg::PH_CHIRP;
            n_last    = r_echo;
            n_frames  = r_frames + 16'd1;
            n_echo    = '0;
            n_running = 1'b1;
        end else if (r_running) begin
            case (r_phase)
                uer_pkg::PH_CHIRP: begin
                    if (r_tick != '0) begin
                        n_tick  = r_tick - 11'd1;
                        n_drive = 1'b1;
                    end else begin
                        n_drive = 1'b0;
                        n_phase = uer_pkg::PH_SETTLE;
                        n_tick  = {{(uer_pkg::TICK_W-uer_pkg::SETTLE_W){1'b0}}, r_settle};
                        n_min   = uer_pkg::MIN_NONE;
                    end
                end
                uer_pkg::PH_SETTLE: begin
                    // The tick that finds the count exhausted takes no sample.
                    if (r_tick == '0) begin
                        n_phase = uer_pkg::PH_DETECT;
                    end else begin
                        n_tick = r_tick - 11'd1;
                        n_min  = min_upd;
                    end
                end
                uer_pkg::PH_DETECT: begin
                    n_tick = r_tick + 11'd1;
                    n_min  = min_upd;
                    if (hit || (r_tick > {1'b0, r_timeout})) begin
                        n_echo    = r_tick;
                        n_phase   = uer_pkg::PH_DONE;
                        n_running = 1'b0;
                        n_found   = 1'b1;
                    end
                end
                default: begin
                    n_running = 1'b0;
                end
            endcase
        end

        n_out.drive_left    = n_drive && n_left;
        n_out.drive_right   = n_drive && !n_left;
        n_out.side_left     = n_left;
        n_out.echo_found    = n_found;
        n_out.echo_count    = n_echo;
        n_out.previous_echo = n_last;
        n_out.frame_number  = n_frames;
        n_out.busy_res      = n_running;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= uer_pkg::THRESHOLD_RST;
            r_burst   <= uer_pkg::BURST_RST;
            r_settle  <= uer_pkg::SETTLE_RST;
            r_timeout <= uer_pkg::TIMEOUT_RST;
        end else if (cfg_fire) begin
            case (i_cfg_index)
                uer_pkg::CFG_ECHO_THRESHOLD: r_thr     <= i_cfg_data;
                uer_pkg::CFG_BURST_TICKS:    r_burst   <= i_cfg_data[uer_pkg::BURST_W-1:0];
                uer_pkg::CFG_SETTLE_TICKS:   r_settle  <= i_cfg_data[uer_pkg::SETTLE_W-1:0];
                uer_pkg::CFG_TIMEOUT_TICKS:  r_timeout <= i_cfg_data[uer_pkg::TOUT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= uer_pkg::PH_CHIRP;
            r_tick      <= '0;
            r_min       <= uer_pkg::MIN_NONE;
            r_left      <= 1'b0;
            r_running   <= 1'b0;
            r_echo      <= '0;
            r_last      <= '0;
            r_frames    <= '0;
            r_drive     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_phase   <= n_phase;
                r_tick    <= n_tick;
                r_min     <= n_min;
                r_left    <= n_left;
                r_running <= n_running;
                r_echo    <= n_echo;
                r_last    <= n_last;
                r_frames  <= n_frames;
                r_drive   <= n_drive;
            end
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

    `ASSERT_CLK(a_fire_loads_result, i_clk, i_rst_n, in_fire |=> o_out_valid, "accepted item left no result")
    `ASSERT_CLK(a_one_side_driven, i_clk, i_rst_n, o_out_valid |-> !(o_out.drive_left && o_out.drive_right), "both transducers driven")
    `ASSERT_CLK(a_found_ends_busy, i_clk, i_rst_n, (o_out_valid && o_out.echo_found) |-> !o_out.busy_res, "echo latched while still busy")
    `ASSERT_CLK(a_frame_starts, i_clk, i_rst_n, (in_fire && (i_in.command == uer_pkg::CMD_FRAME)) |=> (r_running && (r_frames == $past(r_frames) + 16'd1)), "frame command did not start a measurement")

endmodule
